// ===== src/tst_pkg.sv =====
package tst_pkg;

  localparam int TICK_W     = 24;
  localparam int LEN_W      = 24;
  localparam int OP_W       = 2;
  localparam int CNT_W      = 8;
  localparam int IDX_W      = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RAND_W     = 16;
  localparam int IMIN_W     = 8;
  localparam int DBL_W      = 5;
  localparam int MOD_CNT_W  = $clog2(RAND_W);
  localparam int SHIFT_W    = IMIN_W + 16;
  localparam int WIDE_W     = (TICK_W > SHIFT_W) ? TICK_W : SHIFT_W;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [RAND_W-1:0] rand_t;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_HEARD = 2'd3;

  localparam logic [IDX_W-1:0] CFG_INTERVAL_MIN  = 3'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_DOUBLINGS = 3'd1;
  localparam logic [IDX_W-1:0] CFG_REDUNDANCY_K  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd3;
  localparam logic [IDX_W-1:0] CFG_FIXED_CHANNEL = 3'd4;
  localparam logic [IDX_W-1:0] CFG_RANDOM_SEED   = 3'd5;

  localparam rand_t             LFSR_TAPS  = 16'hB400;
  localparam logic [CNT_W-1:0]  FREE_LIMIT = 8'd20;
  localparam logic [CNT_W-1:0]  HEARD_MAX  = 8'hFF;
  localparam logic [DBL_W-1:0]  DBL_MAX    = 5'd16;

  typedef struct packed {
    logic capture;
    logic start;
    logic stop;
    logic heard;
    logic tick;
    logic begin_iv;
    logic mod_start;
    logic sel_half;
    logic set_interval;
    logic set_fire;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            iv_end;
    logic            half_zero;
    logic            mod_done;
  } dp_status_t;

  function automatic rand_t lfsr_next(rand_t v);
    rand_t n;
    n = {1'b0, v[RAND_W-1:1]};
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    if (n == '0) begin
      n = rand_t'(1);
    end
    return n;
  endfunction

  // Maximum interval: Imin shifted by the doubling count, capped at the tick range.
  function automatic tick_t imax_calc(logic [IMIN_W-1:0] imin, logic [DBL_W-1:0] dbl);
    logic [WIDE_W-1:0] m;
    logic [WIDE_W-1:0] lim;
    logic [DBL_W-1:0]  d;
    d   = (dbl > DBL_MAX) ? DBL_MAX : dbl;
    m   = WIDE_W'(imin) << d;
    lim = WIDE_W'({TICK_W{1'b1}});
    if (m > lim) begin
      m = lim;
    end
    return tick_t'(m);
  endfunction

endpackage

// ===== src/tst_channels.sv =====
interface tst_in_if;
  logic                     valid;
  logic                     ready;
  logic [tst_pkg::OP_W-1:0] operation;
  logic                     ready_to_change;

  modport source (output valid, operation, ready_to_change, input ready);
  modport sink (input valid, operation, ready_to_change, output ready);
endinterface

interface tst_out_if;
  logic                      valid;
  logic                      ready;
  logic                      transmit;
  logic                      join_change;
  logic                      attempts_exhausted;
  logic                      running;
  logic [tst_pkg::CNT_W-1:0] attempt_count;
  logic [tst_pkg::LEN_W-1:0] interval_length;

  modport source (output valid, transmit, join_change, attempts_exhausted, running,
                  attempt_count, interval_length, input ready);
  modport sink (input valid, transmit, join_change, attempts_exhausted, running,
                attempt_count, interval_length, output ready);
endinterface

// ===== src/tst_mod.sv =====
module tst_mod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  tst_pkg::rand_t dividend_i,
  input  tst_pkg::tick_t divisor_i,
  output logic           done_o,
  output tst_pkg::tick_t rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tst_pkg::MOD_CNT_W-1:0] cnt_q, cnt_d;
  tst_pkg::rand_t                num_q;
  tst_pkg::tick_t                div_q;
  tst_pkg::tick_t                rem_q;
  logic [tst_pkg::TICK_W:0]      trial;
  logic [tst_pkg::TICK_W:0]      rem_n;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem_q, num_q[tst_pkg::RAND_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_n = trial - {1'b0, div_q};
    end else begin
      rem_n = trial;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tst_pkg::MOD_CNT_W'(tst_pkg::RAND_W - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_n[tst_pkg::TICK_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/tst_dp.sv =====
module tst_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tst_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [tst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [tst_pkg::OP_W-1:0]       operation_i,
  input  logic                           ready_to_change_i,
  input  tst_pkg::dp_cmd_t               cmd_i,
  output tst_pkg::dp_status_t            status_o,
  output logic                           transmit_o,
  output logic                           join_change_o,
  output logic                           attempts_exhausted_o,
  output logic                           running_o,
  output logic [tst_pkg::CNT_W-1:0]      attempt_count_o,
  output logic [tst_pkg::LEN_W-1:0]      interval_length_o
);

  logic [tst_pkg::IMIN_W-1:0] imin_q;
  logic [tst_pkg::DBL_W-1:0]  dbl_q;
  logic [tst_pkg::CNT_W-1:0]  k_q;
  logic [tst_pkg::CNT_W-1:0]  limit_q;
  logic                       fixed_q;
  tst_pkg::rand_t             seed_q;

  logic [tst_pkg::OP_W-1:0]   op_q;
  logic                       rdy_q;
  tst_pkg::tick_t             interval_q;
  tst_pkg::tick_t             fire_q;
  tst_pkg::tick_t             elapsed_q;
  logic [tst_pkg::CNT_W-1:0]  heard_q;
  logic [tst_pkg::CNT_W-1:0]  attempts_q;
  logic                       active_q;
  tst_pkg::rand_t             lfsr_q;
  logic                       tx_q, jc_q, ex_q;

  logic                       tx_out_q, jc_out_q, ex_out_q, run_out_q;
  logic [tst_pkg::CNT_W-1:0]  att_out_q;
  logic [tst_pkg::LEN_W-1:0]  len_out_q;

  logic [tst_pkg::IMIN_W-1:0] imin_eff;
  tst_pkg::tick_t             lo;
  tst_pkg::tick_t             imax;
  tst_pkg::tick_t             span;
  tst_pkg::tick_t             half;
  tst_pkg::tick_t             elapsed_n;
  tst_pkg::rand_t             seed_eff;
  logic [tst_pkg::CNT_W-1:0]  limit;
  logic [tst_pkg::CNT_W-1:0]  att_inc;
  logic                       fire;
  logic                       exh;
  logic                       mod_done;
  tst_pkg::tick_t             mod_rem;

  always_comb begin
    imin_eff  = (imin_q == '0) ? tst_pkg::IMIN_W'(1) : imin_q;
    lo        = tst_pkg::TICK_W'(imin_eff);
    imax      = tst_pkg::imax_calc(imin_eff, dbl_q);
    span      = imax - lo + tst_pkg::TICK_W'(1);
    half      = interval_q >> 1;
    elapsed_n = elapsed_q + tst_pkg::TICK_W'(1);
    seed_eff  = (seed_q == '0) ? tst_pkg::RAND_W'(1) : seed_q;
    limit     = fixed_q ? limit_q : tst_pkg::FREE_LIMIT;
    att_inc   = attempts_q + 1'b1;
    fire      = (elapsed_q == fire_q);
    exh       = fire && (att_inc >= limit);
  end

  tst_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .dividend_i(lfsr_q),
    .divisor_i (cmd_i.sel_half ? half : span),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign status_o.op        = op_q;
  assign status_o.iv_end    = active_q && !exh && (elapsed_n >= interval_q);
  assign status_o.half_zero = (half == '0);
  assign status_o.mod_done  = mod_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imin_q  <= 8'd8;
      dbl_q   <= 5'd8;
      k_q     <= 8'd1;
      limit_q <= 8'd3;
      fixed_q <= 1'b0;
      seed_q  <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tst_pkg::CFG_INTERVAL_MIN:  imin_q  <= cfg_data_i[tst_pkg::IMIN_W-1:0];
        tst_pkg::CFG_MAX_DOUBLINGS: dbl_q   <= cfg_data_i[tst_pkg::DBL_W-1:0];
        tst_pkg::CFG_REDUNDANCY_K:  k_q     <= cfg_data_i[tst_pkg::CNT_W-1:0];
        tst_pkg::CFG_ATTEMPT_LIMIT: limit_q <= cfg_data_i[tst_pkg::CNT_W-1:0];
        tst_pkg::CFG_FIXED_CHANNEL: fixed_q <= cfg_data_i[0];
        tst_pkg::CFG_RANDOM_SEED:   seed_q  <= cfg_data_i[tst_pkg::RAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q       <= tst_pkg::OP_TICK;
      rdy_q      <= 1'b0;
      interval_q <= '0;
      fire_q     <= '0;
      elapsed_q  <= '0;
      heard_q    <= '0;
      attempts_q <= '0;
      active_q   <= 1'b0;
      lfsr_q     <= tst_pkg::RAND_W'(1);
      tx_q       <= 1'b0;
      jc_q       <= 1'b0;
      ex_q       <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        op_q  <= operation_i;
        rdy_q <= ready_to_change_i;
        tx_q  <= 1'b0;
        jc_q  <= 1'b0;
        ex_q  <= 1'b0;
      end else if (cmd_i.start) begin
        lfsr_q     <= tst_pkg::lfsr_next(seed_eff);
        attempts_q <= '0;
        active_q   <= 1'b1;
      end else if (cmd_i.stop) begin
        active_q   <= 1'b0;
        attempts_q <= '0;
        interval_q <= '0;
      end else if (cmd_i.heard) begin
        if (heard_q < tst_pkg::HEARD_MAX) begin
          heard_q <= heard_q + 1'b1;
        end
      end else if (cmd_i.tick) begin
        if (active_q) begin
          if (fire) begin
            tx_q       <= (k_q == '0) || (heard_q < k_q);
            jc_q       <= rdy_q;
            attempts_q <= exh ? '0 : att_inc;
            if (exh) begin
              active_q   <= 1'b0;
              interval_q <= '0;
              ex_q       <= 1'b1;
            end
          end
          if (!exh) begin
            elapsed_q <= elapsed_n;
            // End of the interval: double the length, capped at the maximum.
            if (elapsed_n >= interval_q) begin
              interval_q <= (interval_q <= (imax >> 1)) ? (interval_q << 1) : imax;
            end
          end
        end
      end else if (cmd_i.begin_iv) begin
        lfsr_q    <= tst_pkg::lfsr_next(lfsr_q);
        heard_q   <= '0;
        elapsed_q <= '0;
        if (half == '0) begin
          fire_q <= '0;
        end
      end else if (cmd_i.set_interval) begin
        interval_q <= lo + mod_rem;
      end else if (cmd_i.set_fire) begin
        fire_q <= half + mod_rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tx_out_q  <= tx_q;
      jc_out_q  <= jc_q;
      ex_out_q  <= ex_q;
      run_out_q <= active_q;
      att_out_q <= attempts_q;
      len_out_q <= tst_pkg::LEN_W'(interval_q);
    end
  end

  assign transmit_o           = tx_out_q;
  assign join_change_o        = jc_out_q;
  assign attempts_exhausted_o = ex_out_q;
  assign running_o            = run_out_q;
  assign attempt_count_o      = att_out_q;
  assign interval_length_o    = len_out_q;

endmodule

// ===== src/tst_ctrl.sv =====
module tst_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tst_pkg::dp_status_t status_i,
  output tst_pkg::dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MODGO = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_BEGIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       pick_fire_q, pick_fire_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    pick_fire_d = pick_fire_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status_i.op)
          tst_pkg::OP_START: begin
            cmd_o.start = 1'b1;
            pick_fire_d = 1'b0;
            state_d     = S_MODGO;
          end
          tst_pkg::OP_STOP: begin
            cmd_o.stop = 1'b1;
            state_d    = S_OUT;
          end
          tst_pkg::OP_HEARD: begin
            cmd_o.heard = 1'b1;
            state_d     = S_OUT;
          end
          default: begin
            cmd_o.tick = 1'b1;
            state_d    = status_i.iv_end ? S_BEGIN : S_OUT;
          end
        endcase
      end
      S_MODGO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.sel_half  = pick_fire_q;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        // The first pick sets the interval length, the second the fire point.
        if (status_i.mod_done) begin
          if (pick_fire_q) begin
            cmd_o.set_fire = 1'b1;
            state_d        = S_OUT;
          end else begin
            cmd_o.set_interval = 1'b1;
            state_d            = S_BEGIN;
          end
        end
      end
      S_BEGIN: begin
        cmd_o.begin_iv = 1'b1;
        pick_fire_d    = 1'b1;
        state_d        = status_i.half_zero ? S_OUT : S_MODGO;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pick_fire_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pick_fire_q <= pick_fire_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/trickle_solicit_timer.sv =====
// Stop, heard and most ticks pass from the capture and execute states to the result
// register; a tick that ends an interval also opens a new one and, unless that is one
// tick long, draws its fire point; a start draws the interval length, then does the same.
// Throughput: one item at a time; the next transfer in is taken once the result is
// registered, so a waiting result does not hold the input, but the next result waits
// for it. Each random pick waits for the serial modulo unit to finish.
// Asynchronous active-low reset restores the config and state defaults and stops the timer at once.
module trickle_solicit_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tst_in_if.sink                         in_i,
  tst_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tst_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [tst_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tst_pkg::dp_cmd_t    cmd;
  tst_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;

  tst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tst_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .operation_i         (in_i.operation),
    .ready_to_change_i   (in_i.ready_to_change),
    .cmd_i               (cmd),
    .status_o            (status),
    .transmit_o          (out_o.transmit),
    .join_change_o       (out_o.join_change),
    .attempts_exhausted_o(out_o.attempts_exhausted),
    .running_o           (out_o.running),
    .attempt_count_o     (out_o.attempt_count),
    .interval_length_o   (out_o.interval_length)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

// ===== verif/trickle_solicit_timer_checker.sv =====
`timescale 1ns / 100ps

module trickle_solicit_timer_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tst_in_if                              in_i,
  tst_out_if                             out_i,
  input  logic                           cfg_we_i,
  input  logic [tst_pkg::IDX_W-1:0]      cfg_idx_i,
  input  logic [tst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             errors_o,
  output int                             pending_o
);

  typedef struct packed {
    logic                      transmit;
    logic                      join_change;
    logic                      exhausted;
    logic                      running;
    logic [tst_pkg::CNT_W-1:0] attempts;
    logic [tst_pkg::LEN_W-1:0] length;
  } timer_result_t;

  localparam longint unsigned TICK_MASK = (64'd1 << tst_pkg::TICK_W) - 64'd1;

  // Register copies as the block holds them.
  logic [tst_pkg::IMIN_W-1:0] imin_r;
  logic [tst_pkg::DBL_W-1:0]  dbl_r;
  logic [tst_pkg::CNT_W-1:0]  k_r;
  logic [tst_pkg::CNT_W-1:0]  limit_r;
  logic                       fixed_r;
  logic [tst_pkg::RAND_W-1:0] seed_r;

  // Timer state.
  longint unsigned            cur_len;
  longint unsigned            fire_at;
  longint unsigned            elapsed;
  logic [tst_pkg::CNT_W-1:0]  heard_cnt;
  logic [tst_pkg::CNT_W-1:0]  attempt_cnt;
  logic                       active;
  logic [tst_pkg::RAND_W-1:0] lfsr;

  timer_result_t              pending_results[$];
  int                         error_count = 0;

  assign errors_o = error_count;

  task automatic report_error(string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [tst_pkg::RAND_W-1:0] advance_lfsr();
    logic [tst_pkg::RAND_W-1:0] v;
    v = {1'b0, lfsr[tst_pkg::RAND_W-1:1]};
    if (lfsr[0]) begin
      v = v ^ tst_pkg::LFSR_TAPS;
    end
    if (v == '0) begin
      v = tst_pkg::RAND_W'(1);
    end
    lfsr = v;
    return v;
  endfunction

  function automatic longint unsigned min_len();
    return (imin_r == '0) ? 64'd1 : 64'(imin_r);
  endfunction

  function automatic longint unsigned max_len();
    longint unsigned m;
    int unsigned     d;
    d = (dbl_r > tst_pkg::DBL_MAX) ? 16 : dbl_r;
    m = min_len() << d;
    return (m > TICK_MASK) ? TICK_MASK : m;
  endfunction

  // A new interval clears the heard count and draws a fire point in [I/2, I).
  function automatic void open_interval();
    longint unsigned half;
    longint unsigned r;
    half      = cur_len >> 1;
    r         = 64'(advance_lfsr());
    heard_cnt = '0;
    elapsed   = 0;
    fire_at   = (half == 0) ? 0 : half + r % half;
  endfunction

  function automatic timer_result_t timer_step(logic [tst_pkg::OP_W-1:0] op, logic rtc);
    timer_result_t             res;
    longint unsigned           lo;
    longint unsigned           span;
    longint unsigned           r;
    longint unsigned           m;
    logic [tst_pkg::CNT_W-1:0] lim;
    res = '0;
    case (op)
      tst_pkg::OP_START: begin
        lo      = min_len();
        span    = max_len() - lo + 1;
        lfsr    = (seed_r == '0) ? 16'd1 : seed_r;
        r       = 64'(advance_lfsr());
        cur_len = lo + r % span;
        attempt_cnt = '0;
        active  = 1'b1;
        open_interval();
      end
      tst_pkg::OP_STOP: begin
        active      = 1'b0;
        attempt_cnt = '0;
        cur_len     = 0;
      end
      tst_pkg::OP_HEARD: begin
        if (heard_cnt < tst_pkg::HEARD_MAX) begin
          heard_cnt = heard_cnt + 1'b1;
        end
      end
      default: begin
        if (active) begin
          if (elapsed == fire_at) begin
            lim = fixed_r ? limit_r : tst_pkg::FREE_LIMIT;
            if (k_r == '0 || heard_cnt < k_r) begin
              res.transmit = 1'b1;
            end
            res.join_change = rtc;
            attempt_cnt = attempt_cnt + 1'b1;
            if (attempt_cnt >= lim) begin
              attempt_cnt   = '0;
              active        = 1'b0;
              cur_len       = 0;
              res.exhausted = 1'b1;
            end
          end
          // A fire that exhausts the attempts skips the interval end.
          if (active) begin
            elapsed = (elapsed + 1) & TICK_MASK;
            if (elapsed >= cur_len) begin
              m = max_len();
              if (cur_len <= (m >> 1)) begin
                cur_len = cur_len << 1;
              end else begin
                cur_len = m;
              end
              open_interval();
            end
          end
        end
      end
    endcase
    res.running  = active;
    res.attempts = attempt_cnt;
    res.length   = cur_len[tst_pkg::LEN_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      imin_r      = 8'd8;
      dbl_r       = 5'd8;
      k_r         = 8'd1;
      limit_r     = 8'd3;
      fixed_r     = 1'b0;
      seed_r      = 16'd1;
      cur_len     = 0;
      fire_at     = 0;
      elapsed     = 0;
      heard_cnt   = '0;
      attempt_cnt = '0;
      active      = 1'b0;
      lfsr        = 16'd1;
      pending_results.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tst_pkg::CFG_INTERVAL_MIN:  imin_r  = cfg_data_i[tst_pkg::IMIN_W-1:0];
          tst_pkg::CFG_MAX_DOUBLINGS: dbl_r   = cfg_data_i[tst_pkg::DBL_W-1:0];
          tst_pkg::CFG_REDUNDANCY_K:  k_r     = cfg_data_i[tst_pkg::CNT_W-1:0];
          tst_pkg::CFG_ATTEMPT_LIMIT: limit_r = cfg_data_i[tst_pkg::CNT_W-1:0];
          tst_pkg::CFG_FIXED_CHANNEL: fixed_r = cfg_data_i[0];
          tst_pkg::CFG_RANDOM_SEED:   seed_r  = cfg_data_i[tst_pkg::RAND_W-1:0];
          default: ;
        endcase
      end

      // Results are taken before new work so a stray result cannot match it.
      if (out_i.valid && out_i.ready) begin
        if (pending_results.size() == 0) begin
          report_error("result transfer with no result outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_i.transmit !== want.transmit) begin
            report_error($sformatf("transmit: got %0d, expected %0d",
                                   out_i.transmit, want.transmit));
          end
          if (out_i.join_change !== want.join_change) begin
            report_error($sformatf("join_change: got %0d, expected %0d",
                                   out_i.join_change, want.join_change));
          end
          if (out_i.attempts_exhausted !== want.exhausted) begin
            report_error($sformatf("attempts_exhausted: got %0d, expected %0d",
                                   out_i.attempts_exhausted, want.exhausted));
          end
          if (out_i.running !== want.running) begin
            report_error($sformatf("running: got %0d, expected %0d",
                                   out_i.running, want.running));
          end
          if (out_i.attempt_count !== want.attempts) begin
            report_error($sformatf("attempt_count: got %0d, expected %0d",
                                   out_i.attempt_count, want.attempts));
          end
          if (out_i.interval_length !== want.length) begin
            report_error($sformatf("interval_length: got %0d, expected %0d",
                                   out_i.interval_length, want.length));
          end
        end
      end

      if (in_i.valid && in_i.ready) begin
        pending_results.push_back(timer_step(in_i.operation, in_i.ready_to_change));
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// ===== verif/trickle_solicit_timer_test.sv =====
`timescale 1ns / 100ps

module trickle_solicit_timer_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 60;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [tst_pkg::IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [tst_pkg::IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we;
  logic [tst_pkg::IDX_W-1:0]      cfg_idx;
  logic [tst_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             error_count;
  int                             pending_count;
  int                             cycle_count = 0;
  bit                             idle_en = 1'b1;
  bit                             hold_off_go = 1'b0;

  tst_in_if  in_ch ();
  tst_out_if out_ch ();

  trickle_solicit_timer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  trickle_solicit_timer_checker u_timer_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (error_count),
    .pending_o  (pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= !(idle_en && $urandom_range(0, 99) < 33);
    end
  end

  // Called at a clock edge; returns at the edge of the transfer.
  task automatic send_item(logic [tst_pkg::OP_W-1:0] op, logic rtc);
    while (idle_en && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.ready_to_change <= rtc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Bits above the register width carry junk; the block must ignore them.
  task automatic cfg_write(logic [tst_pkg::IDX_W-1:0] idx, int unsigned value, int width);
    logic [tst_pkg::CFG_DATA_W-1:0] keep;
    keep = (width >= tst_pkg::CFG_DATA_W) ? '1 : tst_pkg::CFG_DATA_W'((1 << width) - 1);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= (tst_pkg::CFG_DATA_W'($urandom) & ~keep) |
                (tst_pkg::CFG_DATA_W'(value) & keep);
  endtask

  task automatic set_config(int unsigned imin, int unsigned dbl, int unsigned k,
                            int unsigned lim, int unsigned fixed, int unsigned seed);
    cfg_write(tst_pkg::CFG_INTERVAL_MIN, imin, tst_pkg::IMIN_W);
    cfg_write(tst_pkg::CFG_MAX_DOUBLINGS, dbl, tst_pkg::DBL_W);
    cfg_write(tst_pkg::CFG_REDUNDANCY_K, k, tst_pkg::CNT_W);
    cfg_write(tst_pkg::CFG_ATTEMPT_LIMIT, lim, tst_pkg::CNT_W);
    cfg_write(tst_pkg::CFG_FIXED_CHANNEL, fixed, 1);
    cfg_write(tst_pkg::CFG_RANDOM_SEED, seed, tst_pkg::RAND_W);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    set_config($urandom_range(1, 6), $urandom_range(0, 3), $urandom_range(0, 3),
               $urandom_range(0, 6), $urandom_range(0, 1), $urandom_range(0, 65535));
  endtask

  // Each run opens with a start so that ticks reach fire points and interval ends.
  task automatic run_phase(int items, int start_pct, int heard_pct, bit with_hold);
    int                       r;
    logic [tst_pkg::OP_W-1:0] op;
    send_item(tst_pkg::OP_START, 1'($urandom_range(0, 1)));
    for (int n = 1; n < items; n++) begin
      if (with_hold && n == 10) begin
        hold_off_go = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < start_pct) begin
        op = tst_pkg::OP_START;
      end else if (r < start_pct + 2) begin
        op = tst_pkg::OP_STOP;
      end else if (r < start_pct + 2 + heard_pct) begin
        op = tst_pkg::OP_HEARD;
      end else begin
        op = tst_pkg::OP_TICK;
      end
      send_item(op, 1'($urandom_range(0, 1)));
    end
    settle();
  endtask

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= tst_pkg::OP_TICK;
    in_ch.ready_to_change <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= tst_pkg::CFG_INTERVAL_MIN;
    cfg_data              <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults; heard, tick and stop while stopped, then a short run.
    send_item(tst_pkg::OP_HEARD, 1'b0);
    send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_STOP, 1'b0);
    send_item(tst_pkg::OP_START, 1'b1);
    repeat (3) send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_HEARD, 1'b0);
    send_item(tst_pkg::OP_TICK, 1'b0);
    send_item(tst_pkg::OP_STOP, 1'b1);
    send_item(tst_pkg::OP_TICK, 1'b1);
    settle();

    // One-tick interval fires at once; a zero limit exhausts on the first fire,
    // infinite redundancy always transmits, and a zero seed falls back to one.
    set_config(1, 0, 0, 0, 1, 0);
    send_item(tst_pkg::OP_START, 1'b0);
    send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_START, 1'b1);
    send_item(tst_pkg::OP_HEARD, 1'b0);
    send_item(tst_pkg::OP_TICK, 1'b0);
    settle();

    // Zero minimum, doublings beyond the cap, top seed, and unused indexes.
    set_config(0, 31, 255, 255, 0, 16'hFFFF);
    cfg_write(CFG_SPARE_LO, $urandom_range(0, 65535), tst_pkg::CFG_DATA_W);
    cfg_write(CFG_SPARE_HI, $urandom_range(0, 65535), tst_pkg::CFG_DATA_W);
    @(posedge clk);
    cfg_we <= 1'b0;
    send_item(tst_pkg::OP_START, 1'b1);
    send_item(tst_pkg::OP_TICK, 1'b0);
    send_item(tst_pkg::OP_HEARD, 1'b1);
    send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_STOP, 1'b0);
    settle();

    // Largest interval range.
    set_config(255, 16, 1, 3, 0, 1);
    send_item(tst_pkg::OP_START, 1'b0);
    send_item(tst_pkg::OP_TICK, 1'b1);
    send_item(tst_pkg::OP_TICK, 1'b0);
    settle();

    // Short intervals on the free limit of twenty, so exhaustion is reached.
    set_config(1, 1, $urandom_range(0, 2), 5, 0, $urandom_range(0, 65535));
    run_phase(100, 1, 10, 1'b0);

    random_config();
    run_phase(70, 5, 15, 1'b1);

    idle_en = 1'b0;
    random_config();
    run_phase(70, 5, 15, 1'b0);
    idle_en = 1'b1;

    // Flood of heard transfers inside one interval drives the count to
    // saturation; with k at its top the fire must not transmit.
    set_config(4, 1, 255, 5, 1, $urandom_range(0, 65535));
    send_item(tst_pkg::OP_START, 1'b0);
    repeat (260) send_item(tst_pkg::OP_HEARD, 1'($urandom_range(0, 1)));
    repeat (12) send_item(tst_pkg::OP_TICK, 1'($urandom_range(0, 1)));
    settle();

    random_config();
    run_phase(70, 4, 20, 1'b0);

    set_config($urandom_range(0, 3), $urandom_range(4, 31), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 65535));
    run_phase(50, 6, 10, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tst_pkg.sv
src/tst_channels.sv
src/tst_mod.sv
src/tst_dp.sv
src/tst_ctrl.sv
src/trickle_solicit_timer.sv
verif/trickle_solicit_timer_checker.sv
verif/trickle_solicit_timer_test.sv
